// ===== design/kne_pkg.sv =====
// shared constants, field layout and controller/datapath interface types
`default_nettype none

package kne_pkg;

    localparam int MAX_ENTITIES = 64;
    localparam int COORD_W      = 16;
    localparam int FIELD_W      = 16;
    localparam int INDEX_W      = 6;
    localparam int RANK_W       = 6;
    localparam int ENT_W        = $clog2(MAX_ENTITIES);
    localparam int SLOT_W       = ENT_W + 1;
    localparam int SLOTS        = 2 * MAX_ENTITIES;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int SQ_W         = 2 * COORD_W;
    localparam int DIST_W       = SQ_W + 1;
    localparam int CMP_W        = (ENT_W > RANK_W) ? ENT_W : RANK_W;
    localparam int TDATA_IN_W   = 80;
    localparam int TDATA_OUT_W  = 8;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic [ENT_W-1:0] ent_idx_t;

    // last field in the lowest bits
    typedef struct packed {
        logic                      descending;
        logic [RANK_W-1:0]         rank;
        logic signed [FIELD_W-1:0] ref_y;
        logic signed [FIELD_W-1:0] ref_x;
        logic                      active;
        logic signed [FIELD_W-1:0] pos_y;
        logic signed [FIELD_W-1:0] pos_x;
        logic [INDEX_W-1:0]        entity_index;
        logic                      team;
    } in_fields_t;

    localparam int IN_W = $bits(in_fields_t);

    typedef struct packed {
        logic     wr_en;
        logic     load_query;
        logic     dist_issue;
        logic     cand_cap;
        logic     scan_issue;
        logic     res_load;
        logic     res_found;
        ent_idx_t rd_addr;
        ent_idx_t cand_idx;
    } cmd_t;

    typedef struct packed {
        logic cand_active;
        logic pipe_busy;
        logic rank_hit;
    } status_t;

endpackage

`default_nettype wire

// ===== design/kne_ctrl.sv =====
// word sequencer: write strobe, distance pass, candidate loop and result handshake
`default_nettype none

module kne_ctrl (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_tvalid,
    input  wire                   s_op,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  wire                   m_tready,
    input  kne_pkg::status_t      status,
    output kne_pkg::cmd_t         cmd
);

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_DIST      = 9'b000000010,
        ST_DIST_WAIT = 9'b000000100,
        ST_CAND      = 9'b000001000,
        ST_CAND_LAT  = 9'b000010000,
        ST_SCAN      = 9'b000100000,
        ST_SCAN_WAIT = 9'b001000000,
        ST_CHECK     = 9'b010000000,
        ST_RESULT    = 9'b100000000
    } state_t;

    localparam kne_pkg::ent_idx_t LAST_IDX = kne_pkg::ent_idx_t'(kne_pkg::MAX_ENTITIES - 1);

    state_t            state_reg, state_next;
    kne_pkg::ent_idx_t i_reg, i_next;
    kne_pkg::ent_idx_t j_reg, j_next;
    logic              found_reg, found_next;
    logic              out_valid_reg, out_valid_next;

    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        found_next = found_reg;
        cmd          = '0;
        cmd.rd_addr  = j_reg;
        cmd.cand_idx = i_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_op == kne_pkg::OP_QUERY) begin
                        cmd.load_query = 1'b1;
                        j_next         = '0;
                        state_next     = ST_DIST;
                    end else if (s_op == kne_pkg::OP_WRITE) begin
                        cmd.wr_en = 1'b1;
                    end
                end
            end
            ST_DIST: begin
                cmd.dist_issue = 1'b1;
                j_next         = j_reg + 1'b1;
                if (j_reg == LAST_IDX) begin
                    state_next = ST_DIST_WAIT;
                end
            end
            ST_DIST_WAIT: begin
                if (!status.pipe_busy) begin
                    i_next     = '0;
                    state_next = ST_CAND;
                end
            end
            ST_CAND: begin
                // distance of the candidate is read here
                cmd.rd_addr = i_reg;
                if (status.cand_active) begin
                    state_next = ST_CAND_LAT;
                end else if (i_reg == LAST_IDX) begin
                    found_next = 1'b0;
                    state_next = ST_RESULT;
                end else begin
                    i_next = i_reg + 1'b1;
                end
            end
            ST_CAND_LAT: begin
                cmd.cand_cap = 1'b1;
                j_next       = '0;
                state_next   = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.scan_issue = 1'b1;
                j_next         = j_reg + 1'b1;
                if (j_reg == LAST_IDX) begin
                    state_next = ST_SCAN_WAIT;
                end
            end
            ST_SCAN_WAIT: begin
                if (!status.pipe_busy) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.rank_hit) begin
                    found_next = 1'b1;
                    state_next = ST_RESULT;
                end else if (i_reg == LAST_IDX) begin
                    found_next = 1'b0;
                    state_next = ST_RESULT;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_CAND;
                end
            end
            ST_RESULT: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.res_load  = 1'b1;
                    cmd.res_found = found_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.res_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

// ===== design/kne_datapath.sv =====
// entity tables, squared distance pipeline, rank counter and result register
`default_nettype none

module kne_datapath (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  kne_pkg::cmd_t                cmd,
    input  kne_pkg::in_fields_t          fields,
    output kne_pkg::status_t             status,
    output logic [kne_pkg::INDEX_W-1:0]  sel_index,
    output logic                         out_of_range
);

    // tables: coordinates undefined until written, active flags in flops
    logic signed [kne_pkg::COORD_W-1:0] x_mem [0:kne_pkg::SLOTS-1];
    logic signed [kne_pkg::COORD_W-1:0] y_mem [0:kne_pkg::SLOTS-1];
    logic [kne_pkg::DIST_W-1:0]         dist_mem [0:kne_pkg::MAX_ENTITIES-1];
    logic [kne_pkg::SLOTS-1:0]          act_reg;

    // query word
    logic                               team_reg;
    logic signed [kne_pkg::COORD_W-1:0] ref_x_reg, ref_y_reg;
    logic [kne_pkg::RANK_W-1:0]         rank_reg;
    logic                               desc_reg;

    // distance pipeline
    logic signed [kne_pkg::COORD_W-1:0] xr_reg, yr_reg;
    logic                               v1_reg, v2_reg, v3_reg;
    kne_pkg::ent_idx_t                  i1_reg, i2_reg, i3_reg;
    logic [kne_pkg::COORD_W-1:0]        ux_reg, uy_reg;
    logic [kne_pkg::SQ_W-1:0]           sqx_reg, sqy_reg;

    // rank scan
    logic [kne_pkg::DIST_W-1:0]         dist_rd_reg, cand_reg;
    logic                               cmp_valid_reg;
    kne_pkg::ent_idx_t                  cmp_j_reg;
    kne_pkg::ent_idx_t                  pos_reg;

    logic [kne_pkg::INDEX_W-1:0]        sel_reg;
    logic                               oor_reg;

    logic [kne_pkg::SLOT_W-1:0]         wr_slot, rd_slot;
    logic                               wr_ok;
    logic signed [kne_pkg::DIFF_W-1:0]  dx, dy;
    logic [kne_pkg::COORD_W-1:0]        ux_c, uy_c;
    logic [kne_pkg::SQ_W-1:0]           sqx_c, sqy_c;
    logic                               j_active, ahead, count_en;

    assign wr_slot = {fields.team, kne_pkg::ent_idx_t'(fields.entity_index)};
    assign wr_ok   = cmd.wr_en && (int'(fields.entity_index) < kne_pkg::MAX_ENTITIES);
    assign rd_slot = {team_reg, cmd.rd_addr};

    assign dx   = kne_pkg::DIFF_W'(xr_reg) - kne_pkg::DIFF_W'(ref_x_reg);
    assign dy   = kne_pkg::DIFF_W'(yr_reg) - kne_pkg::DIFF_W'(ref_y_reg);
    assign ux_c = dx[kne_pkg::DIFF_W-1] ? kne_pkg::COORD_W'(-dx) : kne_pkg::COORD_W'(dx);
    assign uy_c = dy[kne_pkg::DIFF_W-1] ? kne_pkg::COORD_W'(-dy) : kne_pkg::COORD_W'(dy);
    assign sqx_c = ux_reg * ux_reg;
    assign sqy_c = uy_reg * uy_reg;

    // equal distances rank the lower index first in both directions
    always_comb begin
        if (dist_rd_reg == cand_reg) begin
            ahead = (cmp_j_reg < cmd.cand_idx);
        end else if (desc_reg) begin
            ahead = (dist_rd_reg > cand_reg);
        end else begin
            ahead = (dist_rd_reg < cand_reg);
        end
    end

    assign j_active = act_reg[{team_reg, cmp_j_reg}];
    assign count_en = cmp_valid_reg && j_active && (cmp_j_reg != cmd.cand_idx) && ahead;

    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            x_mem[wr_slot] <= fields.pos_x[kne_pkg::COORD_W-1:0];
            y_mem[wr_slot] <= fields.pos_y[kne_pkg::COORD_W-1:0];
        end
        xr_reg <= x_mem[rd_slot];
        yr_reg <= y_mem[rd_slot];
    end

    always_ff @(posedge aclk) begin
        if (v3_reg) begin
            dist_mem[i3_reg] <= kne_pkg::DIST_W'(sqx_reg) + kne_pkg::DIST_W'(sqy_reg);
        end
        dist_rd_reg <= dist_mem[cmd.rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_query) begin
            team_reg  <= fields.team;
            ref_x_reg <= fields.ref_x[kne_pkg::COORD_W-1:0];
            ref_y_reg <= fields.ref_y[kne_pkg::COORD_W-1:0];
            rank_reg  <= fields.rank;
            desc_reg  <= fields.descending;
        end
        i1_reg    <= cmd.rd_addr;
        i2_reg    <= i1_reg;
        i3_reg    <= i2_reg;
        ux_reg    <= ux_c;
        uy_reg    <= uy_c;
        sqx_reg   <= sqx_c;
        sqy_reg   <= sqy_c;
        cmp_j_reg <= cmd.rd_addr;
        if (cmd.cand_cap) begin
            cand_reg <= dist_rd_reg;
            pos_reg  <= '0;
        end else if (count_en) begin
            pos_reg <= pos_reg + 1'b1;
        end
        if (cmd.res_load) begin
            sel_reg <= cmd.res_found ? kne_pkg::INDEX_W'(cmd.cand_idx) : '0;
            oor_reg <= !cmd.res_found;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg       <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            cmp_valid_reg <= 1'b0;
        end else begin
            if (wr_ok) begin
                act_reg[wr_slot] <= fields.active;
            end
            v1_reg        <= cmd.dist_issue;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            cmp_valid_reg <= cmd.scan_issue;
        end
    end

    assign status.cand_active = act_reg[{team_reg, cmd.cand_idx}];
    assign status.pipe_busy   = v1_reg || v2_reg || v3_reg || cmp_valid_reg;
    assign status.rank_hit    = (kne_pkg::CMP_W'(pos_reg) == kne_pkg::CMP_W'(rank_reg));

    assign sel_index    = sel_reg;
    assign out_of_range = oor_reg;

endmodule

`default_nettype wire

// ===== design/kth_nearest_active_entity_select_top.sv =====
// top level: ranked nearest/furthest active entity selection over two tables
//
// channel  dir  bus                                   moves
// s_       in   tvalid/tready/tdata[79:0]/tuser       entity write or ranked query word
// m_       out  tvalid/tready/tdata[7:0]/tuser        selected index and out-of-range flag
//
// a write word gives no result
// a query runs the distance pass, then steps through the candidates in index order:
// an inactive candidate is skipped and an active one is ranked by a scan of the
// distance table, until the rank matches or the last candidate is done
// reset clears active flags and control state; coordinates stay undefined
// the result register holds a word under m_tready low while s_ is idle again
`default_nettype none

module kth_nearest_active_entity_select_top (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // team, entity_index, pos_x, pos_y, active, ref_x, ref_y, rank, descending
    input  wire [kne_pkg::TDATA_IN_W-1:0]     s_tdata,
    // operation
    input  wire                               s_tuser,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // selected_index
    output logic [kne_pkg::TDATA_OUT_W-1:0]   m_tdata,
    // rank_out_of_range
    output logic                              m_tuser
);

    kne_pkg::in_fields_t          fields;
    kne_pkg::cmd_t                cmd;
    kne_pkg::status_t             status;
    logic [kne_pkg::INDEX_W-1:0]  sel_index;
    logic                         out_of_range;

    assign fields = kne_pkg::in_fields_t'(s_tdata[kne_pkg::IN_W-1:0]);

    kne_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_op     (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    kne_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .fields       (fields),
        .status       (status),
        .sel_index    (sel_index),
        .out_of_range (out_of_range)
    );

    assign m_tdata = kne_pkg::TDATA_OUT_W'(sel_index);
    assign m_tuser = out_of_range;

endmodule

`default_nettype wire

// ===== test/tb_kth_nearest_active_entity_select_top.sv =====
// testbench for the ranked nearest/furthest active entity selector
`timescale 1ns / 1ps

module tb_kth_nearest_active_entity_select_top;

    localparam int TEAMS         = 2;
    localparam int ENTRIES       = kne_pkg::MAX_ENTITIES;
    localparam int RANDOM_WORDS  = 40;
    localparam int DRAIN_CYCLES  = 200;
    localparam int CYCLE_LIMIT   = 4_000_000;

    typedef struct {
        logic                     op;
        logic                     team;
        logic [5:0]               entity_index;
        logic signed [15:0]       pos_x;
        logic signed [15:0]       pos_y;
        logic                     active;
        logic signed [15:0]       ref_x;
        logic signed [15:0]       ref_y;
        logic [5:0]               rank;
        logic                     descending;
    } entity_word_t;

    typedef struct packed {
        logic [7:0] index_word;
        logic       out_of_range;
    } pick_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [kne_pkg::TDATA_IN_W-1:0] s_tdata  = '0;
    logic                           s_tuser  = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [kne_pkg::TDATA_OUT_W-1:0] m_tdata;
    logic                           m_tuser;

    kth_nearest_active_entity_select_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor copy of both position tables
    logic signed [15:0] table_x      [TEAMS][ENTRIES];
    logic signed [15:0] table_y      [TEAMS][ENTRIES];
    logic               table_active [TEAMS][ENTRIES];
    // active flags as the generator expects them once its words are taken
    logic               plan_active  [TEAMS][ENTRIES] = '{default: 1'b0};

    entity_word_t pending_words [$];
    pick_t        expected_picks [$];
    entity_word_t word_on_bus;
    kne_pkg::in_fields_t bus_fields;
    pick_t        seen_pick;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int queued_count  = 0;
    int taken_count   = 0;
    int fault_count   = 0;
    int cycle_count   = 0;

    initial begin
        for (int t = 0; t < TEAMS; t++) begin
            for (int i = 0; i < ENTRIES; i++) begin
                table_x[t][i]      = '0;
                table_y[t][i]      = '0;
                table_active[t][i] = 1'b0;
            end
        end
    end

    function automatic pick_t rank_pick(logic tm, logic signed [15:0] rx,
                                        logic signed [15:0] ry, logic [5:0] rk,
                                        logic desc);
        longint span_sq [ENTRIES];
        longint dx;
        longint dy;
        int     pos;
        pick_t  pick;
        pick.index_word   = '0;
        pick.out_of_range = 1'b1;
        for (int i = 0; i < ENTRIES; i++) begin
            dx = longint'(rx) - longint'(table_x[tm][i]);
            dy = longint'(ry) - longint'(table_y[tm][i]);
            span_sq[i] = table_active[tm][i] ? dx * dx + dy * dy : 0;
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (table_active[tm][i]) begin
                pos = 0;
                for (int j = 0; j < ENTRIES; j++) begin
                    if (j != i && table_active[tm][j]) begin
                        // equal distance: lower index ranks first either way
                        if (span_sq[j] == span_sq[i] ? (j < i)
                            : (desc ? (span_sq[j] > span_sq[i])
                                    : (span_sq[j] < span_sq[i])))
                            pos++;
                    end
                end
                if (pos == int'(rk)) begin
                    pick.index_word   = 8'(i);
                    pick.out_of_range = 1'b0;
                    break;
                end
            end
        end
        return pick;
    endfunction

    task automatic absorb_word(entity_word_t w);
        if (w.op == kne_pkg::OP_WRITE) begin
            table_x[w.team][w.entity_index]      = w.pos_x;
            table_y[w.team][w.entity_index]      = w.pos_y;
            table_active[w.team][w.entity_index] = w.active;
        end else begin
            expected_picks = {expected_picks,
                              rank_pick(w.team, w.ref_x, w.ref_y, w.rank, w.descending)};
        end
        taken_count++;
    endtask

    task automatic queue_word(entity_word_t w);
        if (w.op == kne_pkg::OP_WRITE)
            plan_active[w.team][w.entity_index] = w.active;
        pending_words = {pending_words, w};
        queued_count++;
    endtask

    function automatic entity_word_t noise_word();
        entity_word_t w;
        w.op           = 1'($urandom);
        w.team         = 1'($urandom);
        w.entity_index = 6'($urandom);
        w.pos_x        = 16'($urandom);
        w.pos_y        = 16'($urandom);
        w.active       = 1'($urandom);
        w.ref_x        = 16'($urandom);
        w.ref_y        = 16'($urandom);
        w.rank         = 6'($urandom);
        w.descending   = 1'($urandom);
        return w;
    endfunction

    // full range, a tight cluster for ties, or a corner of the grid
    function automatic logic signed [15:0] rand_coord();
        logic signed [15:0] v;
        case ($urandom_range(3))
            1: begin
                v = 16'($urandom_range(8));
                v = v - 16'sd4;
            end
            2: v = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    task automatic send_write(logic tm, logic [5:0] idx, logic signed [15:0] x,
                              logic signed [15:0] y, logic act);
        entity_word_t w;
        w = noise_word();
        w.op           = kne_pkg::OP_WRITE;
        w.team         = tm;
        w.entity_index = idx;
        w.pos_x        = x;
        w.pos_y        = y;
        w.active       = act;
        queue_word(w);
    endtask

    task automatic send_query(logic tm, logic signed [15:0] rx, logic signed [15:0] ry,
                              logic [5:0] rk, logic desc);
        entity_word_t w;
        w = noise_word();
        w.op         = kne_pkg::OP_QUERY;
        w.team       = tm;
        w.ref_x      = rx;
        w.ref_y      = ry;
        w.rank       = rk;
        w.descending = desc;
        queue_word(w);
    endtask

    task automatic random_word();
        logic tm;
        int   live;
        int   roll;
        roll = $urandom_range(99);
        tm   = 1'($urandom);
        if (roll < 10) begin
            queue_word(noise_word());
        end else if (roll < 58) begin
            send_write(tm, $urandom_range(1) ? 6'($urandom) : 6'($urandom_range(7)),
                       rand_coord(), rand_coord(), $urandom_range(99) < 85);
        end else begin
            live = 0;
            for (int i = 0; i < ENTRIES; i++)
                live += plan_active[tm][i];
            send_query(tm, rand_coord(), rand_coord(),
                       (live > 0 && $urandom_range(99) < 80) ?
                           6'($urandom_range(live - 1)) : 6'($urandom),
                       1'($urandom));
        end
    endtask

    // word source
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                absorb_word(word_on_bus);
            if (!s_tvalid || s_tready) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    word_on_bus             = pending_words.pop_front();
                    bus_fields.team         = word_on_bus.team;
                    bus_fields.entity_index = word_on_bus.entity_index;
                    bus_fields.pos_x        = word_on_bus.pos_x;
                    bus_fields.pos_y        = word_on_bus.pos_y;
                    bus_fields.active       = word_on_bus.active;
                    bus_fields.ref_x        = word_on_bus.ref_x;
                    bus_fields.ref_y        = word_on_bus.ref_y;
                    bus_fields.rank         = word_on_bus.rank;
                    bus_fields.descending   = word_on_bus.descending;
                    s_tdata  <= kne_pkg::TDATA_IN_W'(bus_fields);
                    s_tuser  <= word_on_bus.op;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result sink and checker
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_picks.size() == 0) begin
                    fault_count++;
                    $display("%0t: unexpected result word, index %0d flag %0b",
                             $time, m_tdata, m_tuser);
                end else begin
                    seen_pick = expected_picks.pop_front();
                    if (m_tdata !== seen_pick.index_word ||
                        m_tuser !== seen_pick.out_of_range) begin
                        fault_count++;
                        $display("%0t: mismatch, expected index %0d flag %0b, got index %0d flag %0b",
                                 $time, seen_pick.index_word, seen_pick.out_of_range,
                                 m_tdata, m_tuser);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 20;
                    recv_idle_pct = 62;
                end
                1: begin
                    send_idle_pct = 62;
                    recv_idle_pct = 20;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (phase == 0) begin
                // empty table, then corners and a tie at the origin
                send_query(1'b0, 16'sd0, 16'sd0, 6'd0, 1'b0);
                send_write(1'b0, 6'd0, 16'sh8000, 16'sh8000, 1'b1);
                send_write(1'b0, 6'd63, 16'sh7fff, 16'sh7fff, 1'b1);
                send_write(1'b0, 6'd5, 16'sd0, 16'sd0, 1'b1);
                send_write(1'b0, 6'd9, 16'sd0, 16'sd0, 1'b1);
                send_query(1'b0, 16'sh7fff, 16'sh7fff, 6'd0, 1'b0);
                send_query(1'b0, 16'sh7fff, 16'sh7fff, 6'd0, 1'b1);
                send_query(1'b0, 16'sd0, 16'sd0, 6'd0, 1'b0);
                send_query(1'b0, 16'sd0, 16'sd0, 6'd1, 1'b0);
                send_query(1'b0, 16'sd0, 16'sd0, 6'd2, 1'b1);
                send_query(1'b0, 16'sd0, 16'sd0, 6'd3, 1'b1);
                send_query(1'b0, 16'sd0, 16'sd0, 6'd4, 1'b0);
                send_query(1'b0, 16'sd0, 16'sd0, 6'd63, 1'b1);
                // second table stays separate
                send_write(1'b1, 6'd5, 16'sd100, -16'sd100, 1'b1);
                send_query(1'b1, 16'sd0, 16'sd0, 6'd0, 1'b0);
                send_query(1'b1, 16'sd0, 16'sd0, 6'd1, 1'b0);
                // clearing a flag drops the entry from the ranking
                send_write(1'b0, 6'd5, 16'sd0, 16'sd0, 1'b0);
                send_query(1'b0, 16'sd0, 16'sd0, 6'd0, 1'b0);
                send_query(1'b0, 16'sh8000, 16'sh7fff, 6'd1, 1'b0);
                send_write(1'b1, 6'd63, 16'sh8000, 16'sh7fff, 1'b1);
                send_query(1'b1, 16'sh8000, 16'sh8000, 6'd0, 1'b1);
            end
            repeat (RANDOM_WORDS) random_word();
            while (taken_count != queued_count) @(posedge aclk);
        end
        while (expected_picks.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fault_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/kne_pkg.sv
design/kne_ctrl.sv
design/kne_datapath.sv
design/kth_nearest_active_entity_select_top.sv
test/tb_kth_nearest_active_entity_select_top.sv
